/* rtl/tpfpf_pkg.sv */
// Package for the threshold pulse first peak finder.
// Holds field widths, register indexes and the beat/config/result structs.
// No dependencies.
`timescale 1ns / 1ps

package tpfpf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_BITS = 4;
  localparam int IDX_W = 16;
  localparam int THR_W = 15;
  localparam int MINW_W = 16;
  localparam int PED_W = SAMPLE_W + FRAC_BITS;
  // sample minus pedestal, one bit of headroom
  localparam int DIFF_W = PED_W + 1;
  // threshold compare width, room for scaled threshold and signed diff
  localparam int CMP_W = DIFF_W + 1;
  localparam int AREA_W = 38;
  localparam int PEAK_W = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;
  localparam int OUT_DATA_W = 112;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADC_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEDESTAL_MEAN = 2'd2;

  localparam logic [THR_W-1:0] THR_RESET = 15'd5;
  localparam logic [MINW_W-1:0] MINW_RESET = 16'd10;

  typedef struct packed {
    logic [THR_W-1:0] adc_threshold;
    logic [MINW_W-1:0] min_width;
    logic signed [PED_W-1:0] pedestal_mean;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic last_sample;
  } beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] peak_index;
    logic [PEAK_W-1:0] peak_height;
    logic signed [AREA_W-1:0] area;
    logic [IDX_W-1:0] end_index;
    logic [IDX_W-1:0] start_index;
  } result_t;

endpackage

/* rtl/tpfpf_cfg_regs.sv */
// Configuration registers of the pulse finder.
// Depends on tpfpf_pkg.
`timescale 1ns / 1ps

module tpfpf_cfg_regs
  import tpfpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  // register writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adc_threshold <= THR_RESET;
      cfg.min_width <= MINW_RESET;
      cfg.pedestal_mean <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ADC_THRESHOLD: cfg.adc_threshold <= cfg_data[THR_W-1:0];
        REG_MIN_WIDTH:     cfg.min_width <= cfg_data[MINW_W-1:0];
        REG_PEDESTAL_MEAN: cfg.pedestal_mean <= $signed(cfg_data[PED_W-1:0]);
        default: ;
      endcase
    end
  end

endmodule

/* rtl/tpfpf_in_stage.sv */
// Input register of the pulse finder: holds one sample beat for the core.
// Depends on tpfpf_pkg.
`timescale 1ns / 1ps

module tpfpf_in_stage
  import tpfpf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  beat_t in_beat,
  input  logic  advance,
  output logic  held_valid,
  output beat_t held_beat
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_beat <= in_beat;
    end
  end

endmodule

/* rtl/tpfpf_core.sv */
// Pulse state and per-sample logic: threshold test, area sum, first peak
// search and pulse close. Depends on tpfpf_pkg.
`timescale 1ns / 1ps

module tpfpf_core
  import tpfpf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  beat_t   beat,
  input  logic    fire,
  output logic    res_valid,
  output result_t res
);

  logic                     in_pulse;
  logic                     first_peak_seen;
  logic [IDX_W-1:0]         sample_counter;
  logic [IDX_W-1:0]         pulse_start;
  logic signed [AREA_W-1:0] area_sum;
  logic [PEAK_W-1:0]        peak_value;
  logic [IDX_W-1:0]         peak_position;

  logic signed [DIFF_W-1:0] diff;
  logic signed [CMP_W-1:0]  thr_scaled;
  logic                     above;
  logic                     start_new;
  logic                     close_low;
  logic                     close_last;
  logic [IDX_W-1:0]         idx_prev;
  logic [IDX_W-1:0]         width_low;
  logic [IDX_W-1:0]         width_last;

  logic                     fps_base;
  logic [IDX_W-1:0]         start_base;
  logic signed [AREA_W-1:0] area_base;
  logic [PEAK_W-1:0]        peak_base;
  logic [IDX_W-1:0]         pos_base;

  logic                     first_peak_seen_next;
  logic signed [AREA_W-1:0] area_sum_next;
  logic [PEAK_W-1:0]        peak_value_next;
  logic [IDX_W-1:0]         peak_position_next;

  // sample above pedestal, in 2^-FRAC_BITS counts
  assign diff = (DIFF_W'(beat.sample) <<< FRAC_BITS) - DIFF_W'(cfg.pedestal_mean);
  assign thr_scaled = $signed({{(CMP_W - THR_W - FRAC_BITS){1'b0}}, cfg.adc_threshold,
                               {FRAC_BITS{1'b0}}});
  assign above = CMP_W'(diff) >= thr_scaled;

  assign start_new = !in_pulse && above;
  assign close_low = in_pulse && !above;
  assign close_last = beat.last_sample && above;
  assign idx_prev = sample_counter - IDX_W'(1);

  // a new pulse starts from cleared state
  always_comb begin
    if (start_new) begin
      fps_base = 1'b0;
      start_base = sample_counter;
      area_base = '0;
      peak_base = '0;
      pos_base = '0;
    end else begin
      fps_base = first_peak_seen;
      start_base = pulse_start;
      area_base = area_sum;
      peak_base = peak_value;
      pos_base = peak_position;
    end
  end

  // area and first peak update for a sample inside the pulse
  always_comb begin
    area_sum_next = area_base + AREA_W'(diff);
    first_peak_seen_next = fps_base;
    peak_value_next = peak_base;
    peak_position_next = pos_base;
    if (!fps_base) begin
      if (diff > $signed({1'b0, peak_base})) begin
        peak_value_next = diff[PEAK_W-1:0];
        peak_position_next = sample_counter;
      end else begin
        first_peak_seen_next = 1'b1;
      end
    end
  end

  // result select: close below level, or close at window end
  assign width_low = idx_prev - pulse_start;
  assign width_last = sample_counter - start_base;

  always_comb begin
    if (close_low) begin
      res_valid = width_low >= cfg.min_width;
      res.start_index = pulse_start;
      res.end_index = idx_prev;
      res.area = area_sum;
      res.peak_height = peak_value;
      res.peak_index = peak_position;
    end else begin
      res_valid = close_last && (width_last >= cfg.min_width);
      res.start_index = start_base;
      res.end_index = sample_counter;
      res.area = area_sum_next;
      res.peak_height = peak_value_next;
      res.peak_index = peak_position_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_pulse <= 1'b0;
      sample_counter <= '0;
    end else if (fire) begin
      in_pulse <= above && !beat.last_sample;
      sample_counter <= beat.last_sample ? '0 : sample_counter + IDX_W'(1);
    end
  end

  // pulse payload, only read while a pulse is open
  always_ff @(posedge clk) begin
    if (fire) begin
      first_peak_seen <= first_peak_seen_next;
      pulse_start <= start_base;
      area_sum <= area_sum_next;
      peak_value <= peak_value_next;
      peak_position <= peak_position_next;
    end
  end

endmodule

/* rtl/tpfpf_out_reg.sv */
// Output register of the pulse finder: holds one result beat until taken.
// Depends on tpfpf_pkg.
`timescale 1ns / 1ps

module tpfpf_out_reg
  import tpfpf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

/* rtl/threshold_pulse_first_peak_finder.sv */
// Threshold pulse finder that reports the first peak of each pulse.
// Depends on tpfpf_pkg and the tpfpf_* submodules.
//
// Samples stream in one beat per clock, tlast marking the last sample of a
// window. A pulse opens at a sample at or above pedestal + threshold and
// closes at the first sample below it, or at the window end; it is reported
// when end - start reaches min_width. Each sample passes an input register
// and the compare logic (threshold compare, 38-bit area add, peak compare)
// into the output register, so the block takes one sample every cycle. A
// result is loaded as the closing sample leaves the input register. The
// input side stalls only while a result is pending in a full output
// register that the sink does not take. Configuration writes are accepted
// every cycle and must be made while no samples are in flight.
`timescale 1ns / 1ps

module threshold_pulse_first_peak_finder
  import tpfpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // sample stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
  input  logic                  s_tlast,   // last_sample
  // pulse result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // start_index, end_index, area,
                                           // peak_height, peak_index, zero pad
);

  cfg_t    cfg;
  beat_t   in_beat;
  beat_t   held_beat;
  logic    held_valid;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t out_res;

  tpfpf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_beat.sample = $signed(s_tdata);
  assign in_beat.last_sample = s_tlast;

  tpfpf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_beat    (in_beat),
    .advance    (advance),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  // a held sample moves on unless its result has nowhere to go
  assign advance = held_valid && (!res_valid || !m_tvalid || m_tready);

  tpfpf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .beat      (held_beat),
    .fire      (advance),
    .res_valid (res_valid),
    .res       (res)
  );

  tpfpf_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .res       (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = OUT_DATA_W'(out_res);

endmodule

/* test/tb_top.sv */
// Self-checking bench for threshold_pulse_first_peak_finder.
// Predicts each reported pulse from the accepted samples and checks every result beat.
// Depends on tpfpf_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_top;
  import tpfpf_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 180;

  // register index past the end of the list, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata = '0;
  logic                  s_tlast = 1'b0;

  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  threshold_pulse_first_peak_finder u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #10 clk = ~clk;

  // pending sample beats and predicted pulses
  beat_t   beat_q[$];
  result_t pulse_q[$];
  int      beats_total = 0;
  int      beats_done = 0;
  int      fail_count = 0;

  // traffic shaping knobs set by the stimulus process
  bit      calm = 1'b0;
  bit      sink_hold_arm = 1'b0;
  int      sink_hold_left = SINK_HOLD_CYCLES;

  // local copy of the registers
  logic [THR_W-1:0]        thr_cfg = THR_RESET;
  logic [MINW_W-1:0]       minw_cfg = MINW_RESET;
  logic signed [PED_W-1:0] ped_cfg = '0;

  // pulse tracker state
  bit                      pk_open = 1'b0;
  bit                      pk_done = 1'b0;
  logic [IDX_W-1:0]        idx_count = '0;
  logic [IDX_W-1:0]        pk_start = '0;
  logic [AREA_W-1:0]       area_acc = '0;
  logic signed [PED_W:0]   peak_val = '0;
  logic [IDX_W-1:0]        peak_at = '0;

  function automatic void clear_pulse();
    pk_open = 1'b0;
    pk_done = 1'b0;
    pk_start = '0;
    area_acc = '0;
    peak_val = '0;
    peak_at = '0;
  endfunction

  // close the open pulse; report it only if wide enough
  function automatic bit close_pulse(input logic [IDX_W-1:0] end_idx, output result_t res);
    logic [IDX_W-1:0] width;
    bit wide;
    width = end_idx - pk_start;
    wide = (width >= minw_cfg);
    res.start_index = pk_start;
    res.end_index = end_idx;
    res.area = area_acc;
    res.peak_height = peak_val[PEAK_W-1:0];
    res.peak_index = peak_at;
    clear_pulse();
    return wide;
  endfunction

  // advance the pulse tracker by one sample; returns 1 when a pulse is reported
  function automatic bit track_sample(input logic signed [SAMPLE_W-1:0] smp,
                                      input logic at_end, output result_t res);
    longint scaled;
    longint level;
    longint diff_l;
    logic signed [PED_W:0] diff;
    logic [IDX_W-1:0] idx;
    bit above;
    bit got;
    scaled = longint'(smp) * (longint'(1) << FRAC_BITS);
    level = longint'(thr_cfg) * (longint'(1) << FRAC_BITS) + longint'(ped_cfg);
    diff_l = scaled - longint'(ped_cfg);
    diff = diff_l[PED_W:0];
    above = (scaled >= level);
    idx = idx_count;
    got = 1'b0;
    if (!pk_open && above) begin
      clear_pulse();
      pk_open = 1'b1;
      pk_start = idx;
    end
    if (pk_open && !above) got = close_pulse(idx - 1'b1, res);
    if (pk_open) begin
      area_acc = area_acc + {{(AREA_W-PED_W-1){diff[PED_W]}}, diff};
      // first peak: follow only while strictly rising
      if (!pk_done) begin
        if (peak_val < diff) begin
          peak_val = diff;
          peak_at = idx;
        end else begin
          pk_done = 1'b1;
        end
      end
    end
    idx_count = idx + 1'b1;
    if (at_end) begin
      if (pk_open) got = close_pulse(idx, res);
      clear_pulse();
      idx_count = '0;
    end
    return got;
  endfunction

  // sample driver
  always @(posedge clk) begin
    beat_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (beat_q.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
        nxt = beat_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= nxt.sample;
        s_tlast <= nxt.last_sample;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // input monitor: predict from every accepted sample beat
  always @(posedge clk) begin
    result_t r;
    if (!rst && s_tvalid && s_tready) begin
      if (track_sample(s_tdata, s_tlast, r)) pulse_q.insert(pulse_q.size(), r);
      beats_done++;
    end
  end

  // result sink, with one long hold-off once armed
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_hold_arm && sink_hold_left != 0) begin
      m_tready <= 1'b0;
      sink_hold_left--;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 22);
    end
  end

  task automatic check_field(input string name, input longint want, input longint seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fail_count++;
    end
  endtask

  // output monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    result_t got_r;
    result_t want_r;
    if (!rst && m_tvalid && m_tready) begin
      got_r = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (pulse_q.size() == 0) begin
        $error("unexpected pulse beat: start %0d end %0d", got_r.start_index, got_r.end_index);
        fail_count++;
      end else begin
        want_r = pulse_q.pop_front();
        check_field("start_index", longint'(want_r.start_index), longint'(got_r.start_index));
        check_field("end_index", longint'(want_r.end_index), longint'(got_r.end_index));
        check_field("area", longint'(want_r.area), longint'(got_r.area));
        check_field("peak_height", longint'(want_r.peak_height), longint'(got_r.peak_height));
        check_field("peak_index", longint'(want_r.peak_index), longint'(got_r.peak_index));
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ADC_THRESHOLD: thr_cfg = data[THR_W-1:0];
      REG_MIN_WIDTH:     minw_cfg = data[MINW_W-1:0];
      REG_PEDESTAL_MEAN: ped_cfg = data[PED_W-1:0];
      default: ;
    endcase
  endtask

  // wait for all beats and results, then let the pipeline empty
  task automatic drain_and_settle();
    while (beats_done != beats_total || pulse_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_sample(input longint v, input bit at_end);
    beat_t b;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    b.sample = v[SAMPLE_W-1:0];
    b.last_sample = at_end;
    beat_q.insert(beat_q.size(), b);
    beats_total++;
  endtask

  // lowest sample value that counts as on or above the threshold
  function automatic longint onset_level();
    return longint'(thr_cfg) +
           ((longint'(ped_cfg) + (longint'(1) << FRAC_BITS) - 1) >>> FRAC_BITS);
  endfunction

  // one waveform segment: baseline noise with pulses of random shape
  task automatic queue_window(input int len, input int pulse_pct, input bit mark_end);
    longint lvl;
    longint v;
    int k;
    int j;
    int plen;
    int top;
    int amp;
    lvl = onset_level();
    k = 0;
    while (k < len) begin
      if ($urandom_range(99) < pulse_pct) begin
        plen = $urandom_range(24, 1);
        top = $urandom_range(plen - 1, 0);
        amp = $urandom_range(3000, 0);
        j = 0;
        while (j < plen && k < len) begin
          if (j <= top) v = lvl + amp * (j + 1) / (top + 1);
          else v = lvl + amp * (plen - j) / (plen - top);
          push_sample(v + $urandom_range(2, 0), mark_end && k == len - 1);
          j++;
          k++;
        end
      end else begin
        case ($urandom_range(9, 0))
          0: v = longint'(shortint'($urandom));
          1: v = lvl - 1;
          2: v = lvl;
          default: v = lvl - $urandom_range(60, 1);
        endcase
        push_sample(v, mark_end && k == len - 1);
        k++;
      end
    end
  endtask

  task automatic random_phase(input int n_items, input int pulse_pct);
    int done_items;
    int len;
    write_reg(REG_ADC_THRESHOLD, {5'($urandom), 15'($urandom_range(400, 0))});
    write_reg(REG_MIN_WIDTH, {4'($urandom), 16'($urandom_range(12, 0))});
    if ($urandom_range(3, 0) == 0) write_reg(REG_PEDESTAL_MEAN, 20'($urandom));
    else write_reg(REG_PEDESTAL_MEAN, 20'($urandom_range(40000, 0) - 20000));
    done_items = 0;
    while (done_items < n_items) begin
      len = $urandom_range(60, 5);
      queue_window(len, pulse_pct, 1'b1);
      done_items += len;
    end
  endtask

  // stimulus and end of run
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset register values
    queue_window(40, 8, 1'b1);
    queue_window(40, 8, 1'b1);
    drain_and_settle();

    // directed: flat pulse, tie, close on marked sample, open at window end
    write_reg(REG_ADC_THRESHOLD, 20'd0);
    write_reg(REG_MIN_WIDTH, 20'd0);
    write_reg(REG_PEDESTAL_MEAN, 20'd0);
    push_sample(-32768, 1'b0);
    push_sample(0, 1'b0);
    push_sample(0, 1'b0);
    push_sample(0, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(5, 1'b0);
    push_sample(10, 1'b0);
    push_sample(10, 1'b0);
    push_sample(20, 1'b0);
    push_sample(-5, 1'b1);
    push_sample(32767, 1'b0);
    push_sample(32767, 1'b0);
    push_sample(1, 1'b1);
    push_sample(7, 1'b1);
    drain_and_settle();

    // lowest pedestal: every sample is on the pulse, largest peak height
    write_reg(REG_PEDESTAL_MEAN, 20'h80000);
    push_sample(-32768, 1'b0);
    push_sample(32767, 1'b0);
    push_sample(0, 1'b0);
    push_sample(32767, 1'b1);
    drain_and_settle();

    // highest level and width: nothing can be reported; bad index ignored
    write_reg(REG_ADC_THRESHOLD, 20'hFFFFF);
    write_reg(REG_MIN_WIDTH, 20'hFFFFF);
    write_reg(REG_PEDESTAL_MEAN, 20'h7FFFF);
    write_reg(REG_UNUSED, 20'($urandom));
    queue_window(30, 10, 1'b1);
    drain_and_settle();

    // random phases; one without idling, one with a long sink hold-off
    random_phase(PHASE_ITEMS, 8);
    drain_and_settle();
    calm = 1'b1;
    random_phase(PHASE_ITEMS, 12);
    drain_and_settle();
    calm = 1'b0;
    random_phase(PHASE_ITEMS, 6);
    drain_and_settle();
    sink_hold_arm = 1'b1;
    random_phase(PHASE_ITEMS, 15);
    drain_and_settle();
    random_phase(PHASE_ITEMS, 10);
    drain_and_settle();
    random_phase(PHASE_ITEMS, 8);
    drain_and_settle();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(20_000_000);
    $display("status: fail");
    $finish;
  end

endmodule
